// ----- sv/mctp_pkg.sv -----
// Shared types, constants and helpers for the multicore copy tiling planner.
// No dependencies; every other file imports this package.
package mctp_pkg;

  localparam int CountW = 40;
  localparam int TileW  = 24;
  localparam int CoreW  = 8;
  localparam int BufW   = 25;
  localparam int CodeW  = 2;

  localparam logic [BufW-1:0]  BufMax     = 25'd16777216;
  localparam logic [BufW-1:0]  ReserveB   = 25'd8192;
  localparam logic [BufW-1:0]  BufReset   = 25'd196608;
  localparam logic [CoreW-1:0] CoreReset  = 8'd48;
  localparam logic [11:0]      MinChunkB  = 12'd2048;
  localparam logic [5:0]       BlockB     = 6'd32;

  typedef enum logic [2:0] {
    STAT_OK, STAT_NO_CORES, STAT_SMALL_BUF, STAT_SINGLE, STAT_NO_ROOM, STAT_ADJ_BAD
  } status_t;

  typedef enum logic [0:0] {CFG_BUF, CFG_CORES} cfg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_LOOPS, PH_PER, PH_USED, PH_PERC, PH_LASTC, PH_CHECK,
    PH_REM, PH_ALT, PH_ADJ, PH_OUT
  } phase_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic [CodeW-1:0]  code;
    logic [CoreW-1:0]  cores;
    logic [TileW-1:0]  maxf;
    logic [TileW-1:0]  tile;
    status_t           status;
    logic              fast;
  } job_t;

  function automatic logic [TileW-1:0] blk_mask(input logic [CodeW-1:0] code);
    logic [5:0] blk;
    blk = BlockB >> code;
    return TileW'(blk - 6'd1);
  endfunction

endpackage

// ----- sv/multicore_copy_tiling_planner.sv -----
// Top level of the multicore copy tiling planner.
// Depends on mctp_pkg, mctp_front, mctp_queue and mctp_back.
//
// A job whose answer follows from the checks alone (no cores, small buffer, empty job,
// single core, no tile room) skips the divider and goes straight to the result. A job
// that is planned runs four divisions on a shared 40-step divider, and a re-plan adds
// up to two more divisions and a second spread.
// A two-entry queue takes new jobs while one is planned, and a full result waits in the
// output register while the next job is planned.
module multicore_copy_tiling_planner import mctp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [24:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // element_count[39:0], element_size_log2[41:40]
  input  logic [47:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[2:0], tile_key[4:3], cores_used[12:5], tile_elements[36:13],
  // tiles_per_core[76:37], tiles_last_core[116:77], last_tile_elements[140:117]
  output logic [143:0] out_tdata
);

  job_t job, head;
  logic full, q_valid, q_pop;

  assign in_tready = !full;

  mctp_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .count(in_tdata[39:0]),
    .code(in_tdata[41:40]), .job(job)
  );

  mctp_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(in_tvalid && !full), .push_job(job), .full(full),
    .pop(q_pop), .valid(q_valid), .head(head)
  );

  mctp_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_head(head), .q_pop(q_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != STAT_OK |-> out_tdata[140:5] == '0)
    else $error("error result carries nonzero plan fields");
  a_tile_cores: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == STAT_OK && out_tdata[36:13] != '0
      |-> out_tdata[12:5] != '0)
    else $error("planned job reports no cores");
  a_last_core: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[76:37] != '0
      |-> out_tdata[116:77] != '0 && out_tdata[116:77] <= out_tdata[76:37])
    else $error("last core tile count out of range");
`endif

endmodule

// ----- sv/mctp_front.sv -----
// Front end: configuration registers and classification of incoming jobs.
// Depends on mctp_pkg.
module mctp_front import mctp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [BufW-1:0]   cfg_data,
  input  logic [CountW-1:0] count,
  input  logic [CodeW-1:0]  code,
  output job_t              job
);

  logic [BufW-1:0]  lbb_r;
  logic [CoreW-1:0] cores_r;
  logic [BufW-1:0]  ub;
  logic [BufW-1:0]  room;
  logic [TileW-1:0] maxf;
  logic [TileW-1:0] mask;
  logic [TileW-1:0] fm;
  logic [TileW-1:0] fa;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lbb_r   <= BufReset;
      cores_r <= CoreReset;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_BUF) begin
        lbb_r <= cfg_data;
      end else begin
        cores_r <= cfg_data[CoreW-1:0];
      end
    end
  end

  always_comb begin
    ub   = (lbb_r > BufMax) ? BufMax : lbb_r;
    room = (ub > ReserveB) ? (ub - ReserveB) : '0;
    maxf = TileW'((room >> 1) >> code);
    mask = blk_mask(code);
    fm   = (count < {16'd0, maxf}) ? count[TileW-1:0] : maxf;
    fa   = fm & ~mask;
    if (fa == '0) begin
      fa = mask + TileW'(1);
    end
    job.count  = count;
    job.code   = code;
    job.cores  = cores_r;
    job.maxf   = maxf;
    job.tile   = fa;
    job.fast   = 1'b1;
    if (cores_r == '0) begin
      job.status = STAT_NO_CORES;
    end else if (ub <= ReserveB) begin
      job.status = STAT_SMALL_BUF;
    end else if (count == '0) begin
      job.status = STAT_OK;
    end else if (cores_r == 8'd1) begin
      job.status = STAT_SINGLE;
    end else if (maxf == '0) begin
      job.status = STAT_NO_ROOM;
    end else begin
      job.status = STAT_OK;
      job.fast   = 1'b0;
    end
  end

endmodule

// ----- sv/mctp_queue.sv -----
// Two-entry job queue between the front end and the planning back end.
// Depends on mctp_pkg.
module mctp_queue import mctp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t head
);

  job_t       mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_job;
    end
  end

endmodule

// ----- sv/mctp_div.sv -----
// Shared restoring divider, one quotient bit per cycle, 40-bit operands.
// Depends on mctp_pkg.
module mctp_div import mctp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CountW-1:0] dividend,
  input  logic [CountW-1:0] divisor,
  output logic              done,
  output logic [CountW-1:0] quo,
  output logic [CountW-1:0] rem
);

  logic [CountW-1:0] rem_r, rem_nxt;
  logic [CountW-1:0] quo_r, quo_nxt;
  logic [CountW-1:0] dvs_r;
  logic [5:0]        cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CountW:0]   sh;
  logic              ge;

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

  always_comb begin
    sh       = {rem_r, quo_r[CountW-1]};
    ge       = (sh >= {1'b0, dvs_r});
    rem_nxt  = ge ? CountW'(sh - {1'b0, dvs_r}) : sh[CountW-1:0];
    quo_nxt  = {quo_r[CountW-2:0], ge};
    cnt_nxt  = cnt_r + 6'd1;
    busy_nxt = busy_r && (cnt_r != 6'(CountW - 1));
    done_nxt = busy_r && (cnt_r == 6'(CountW - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= busy_r ? cnt_nxt : cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

endmodule

// ----- sv/mctp_back.sv -----
// Back end: plan sequencer that drives the shared divider and holds the result word.
// Depends on mctp_pkg and mctp_div.
module mctp_back import mctp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  job_t         q_head,
  output logic         q_pop,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata
);

  phase_t            ph_r, ph_nxt;
  job_t              job_r;
  status_t           stat_r;
  logic [TileW-1:0]  f_r;
  logic [CountW-1:0] loops_r, per_r, pc_r, lc_r;
  logic [CoreW-1:0]  used_r;
  logic [TileW-1:0]  lt_r;
  logic              pass2_r, go_r, out_valid_r;
  logic [143:0]      out_data_r;

  logic              div_start, div_done;
  logic [CountW-1:0] div_a, div_b, div_q, div_rm, qc;
  logic              is_div, load_out, adj_ok;
  logic [TileW-1:0]  mask, chunk, f_adj;
  logic [CountW:0]   fb, fc;
  logic [47:0]       prod;
  logic [143:0]      res;

  mctp_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quo(div_q), .rem(div_rm)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign q_pop      = (ph_r == PH_IDLE) && q_valid;
  assign load_out   = (ph_r == PH_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    is_div = (ph_r == PH_LOOPS) || (ph_r == PH_PER) || (ph_r == PH_USED) ||
             (ph_r == PH_PERC) || (ph_r == PH_REM) || (ph_r == PH_ALT);
    div_start = is_div && !go_r;
    qc   = div_q + CountW'(div_rm != '0);
    mask = blk_mask(job_r.code);
    chunk = TileW'(MinChunkB >> job_r.code);
    fb   = ({1'b0, div_q} + (CountW+1)'(mask)) & ~((CountW+1)'(mask));
    fc   = (fb < (CountW+1)'(chunk)) ? (CountW+1)'(chunk) : fb;
    f_adj = (fc > (CountW+1)'(job_r.maxf)) ? (job_r.maxf & ~mask) : fc[TileW-1:0];
    adj_ok = (f_adj != '0);
    prod = 48'(used_r - 8'd1) * 48'(pc_r);
    case (ph_r)
      PH_LOOPS: begin div_a = job_r.count; div_b = CountW'(f_r);           end
      PH_PER:   begin div_a = loops_r;     div_b = CountW'(job_r.cores);   end
      PH_USED:  begin div_a = loops_r;     div_b = per_r;                  end
      PH_PERC:  begin div_a = loops_r;     div_b = CountW'(used_r);        end
      PH_REM:   begin div_a = job_r.count; div_b = CountW'(job_r.cores);   end
      PH_ALT:   begin div_a = job_r.count; div_b = CountW'(job_r.cores - 8'd1); end
      default:  begin div_a = job_r.count; div_b = CountW'(f_r);           end
    endcase
  end

  always_comb begin
    ph_nxt = ph_r;
    case (ph_r)
      PH_IDLE:  if (q_valid) ph_nxt = q_head.fast ? PH_OUT : PH_LOOPS;
      PH_LOOPS: if (go_r && div_done) ph_nxt = PH_PER;
      PH_PER:   if (go_r && div_done) ph_nxt = PH_USED;
      PH_USED:  if (go_r && div_done) ph_nxt = PH_PERC;
      PH_PERC:  if (go_r && div_done) ph_nxt = PH_LASTC;
      PH_LASTC: ph_nxt = PH_CHECK;
      PH_CHECK: begin
        if (pass2_r || used_r == job_r.cores || pc_r > CountW'(1)) begin
          ph_nxt = PH_OUT;
        end else begin
          ph_nxt = PH_REM;
        end
      end
      PH_REM:   if (go_r && div_done) ph_nxt = (div_rm == '0) ? PH_ADJ : PH_ALT;
      PH_ALT:   if (go_r && div_done) ph_nxt = PH_ADJ;
      PH_ADJ:   ph_nxt = adj_ok ? PH_LOOPS : PH_OUT;
      PH_OUT:   if (load_out) ph_nxt = PH_IDLE;
      default:  ph_nxt = PH_IDLE;
    endcase
  end

  always_comb begin
    res = '0;
    res[2:0] = stat_r;
    res[4:3] = job_r.code;
    if (stat_r == STAT_OK) begin
      if (job_r.fast) begin
        res[12:5] = 8'd1;
      end else begin
        res[12:5]    = used_r;
        res[36:13]   = f_r;
        res[76:37]   = pc_r;
        res[116:77]  = lc_r;
        res[140:117] = lt_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt;
      if (div_start) begin
        go_r <= 1'b1;
      end else if (div_done) begin
        go_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= res;
    end
    case (ph_r)
      PH_IDLE: begin
        if (q_valid) begin
          job_r   <= q_head;
          stat_r  <= q_head.status;
          f_r     <= q_head.tile;
          pass2_r <= 1'b0;
        end
      end
      PH_LOOPS: if (go_r && div_done) begin
        loops_r <= qc;
        lt_r    <= (div_rm == '0) ? f_r : div_rm[TileW-1:0];
      end
      PH_PER:   if (go_r && div_done) per_r  <= qc;
      PH_USED:  if (go_r && div_done) used_r <= qc[CoreW-1:0];
      PH_PERC:  if (go_r && div_done) pc_r   <= qc;
      PH_LASTC: lc_r <= loops_r - prod[CountW-1:0];
      PH_ADJ: begin
        if (adj_ok) begin
          f_r     <= f_adj;
          pass2_r <= 1'b1;
        end else begin
          stat_r <= STAT_ADJ_BAD;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for multicore_copy_tiling_planner: directed and random copy jobs
// under several buffer and core settings, each result checked against an in-bench planner.
// Depends on mctp_pkg and the planner RTL.
module testbench import mctp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t           st;
    logic [1:0]        key;
    logic [7:0]        used;
    logic [23:0]       tile;
    logic [39:0]       per_core;
    logic [39:0]       last_core;
    logic [23:0]       last_tile;
  } plan_res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_index = 1'b0;
  logic [24:0]  cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [47:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;

  longint unsigned buf_bytes = 196608;
  longint unsigned n_cores = 48;
  plan_res_t       pending_plans[$];
  int              errors = 0;
  int              jobs_sent = 0;
  int              plans_checked = 0;
  int              replans = 0;
  int              stall_left = 0;
  bit              no_idle = 1'b0;

  multicore_copy_tiling_planner dut (.*);

  always #4 clk = ~clk;

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint unsigned cdiv(longint unsigned a, longint unsigned b);
    return (a + b - 1) / b;
  endfunction

  function automatic void spread_tiles(input longint unsigned n, input longint unsigned f,
                                       input longint unsigned cores, ref plan_res_t r);
    longint unsigned loops, per, used, perc;
    loops = cdiv(n, f);
    per = cdiv(loops, cores);
    used = cdiv(loops, per);
    perc = cdiv(loops, used);
    r.used = used[7:0];
    r.per_core = perc[39:0];
    r.last_core = 40'(loops - (used - 1) * perc);
    r.last_tile = (n % f == 0) ? f[23:0] : 24'(n % f);
  endfunction

  function automatic plan_res_t plan_copy(longint unsigned n, logic [1:0] code);
    plan_res_t r;
    longint unsigned elem, blk, ub, maxf, f;
    r = '{st: STAT_OK, key: code, used: 0, tile: 0, per_core: 0, last_core: 0, last_tile: 0};
    elem = 1 << code;
    blk = 32 / elem;
    ub = buf_bytes > 16777216 ? 16777216 : buf_bytes;
    if (n_cores == 0) r.st = STAT_NO_CORES;
    else if (ub <= 8192) r.st = STAT_SMALL_BUF;
    else if (n == 0) r.used = 1;
    else if (n_cores == 1) r.st = STAT_SINGLE;
    else begin
      maxf = (ub - 8192) / 2 / elem;
      if (maxf == 0) r.st = STAT_NO_ROOM;
      else begin
        f = n < maxf ? n : maxf;
        f = (f / blk) * blk;
        if (f == 0) f = blk;
        spread_tiles(n, f, n_cores, r);
        if (!(r.used == n_cores || r.per_core > 1)) begin
          replans++;
          f = (n % n_cores == 0) ? n / n_cores : n / (n_cores - 1);
          f = cdiv(f, blk) * blk;
          if (f < 2048 / elem) f = 2048 / elem;
          if (f > maxf) f = (maxf / blk) * blk;
          if (f == 0) begin
            r.st = STAT_ADJ_BAD;
            r.used = 0; r.per_core = 0; r.last_core = 0; r.last_tile = 0;
          end else spread_tiles(n, f, n_cores, r);
        end
        if (r.st == STAT_OK) r.tile = f[23:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    plan_res_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      plans_checked++;
      if (pending_plans.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        errors++;
      end else begin
        e = pending_plans.pop_front();
        if ({e.last_tile, e.last_core, e.per_core, e.tile, e.used, e.key, e.st}
            !== out_tdata[140:0]) begin
          $display("%0t: mismatch expected st=%0d key=%0d used=%0d tile=%0d per=%0d last=%0d lt=%0d",
                   $time, e.st, e.key, e.used, e.tile, e.per_core, e.last_core, e.last_tile);
          $display("%0t:          actual st=%0d key=%0d used=%0d tile=%0d per=%0d last=%0d lt=%0d",
                   $time, out_tdata[2:0], out_tdata[4:3], out_tdata[12:5], out_tdata[36:13],
                   out_tdata[76:37], out_tdata[116:77], out_tdata[140:117]);
          errors++;
        end
      end
      stall_left = no_idle ? 0 : $urandom_range(0, 3);
      if (stall_left > 0) out_tready <= 1'b0;
    end else if (stall_left > 1) begin
      stall_left--;
    end else begin
      stall_left = 0;
      out_tready <= 1'b1;
    end
  end

  task automatic send_job(input longint unsigned n, input logic [1:0] code);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, code, n[39:0]};
    do @(posedge clk); while (!in_tready);
    pending_plans.push_back(plan_copy(n & 64'hFF_FFFF_FFFF, code));
    jobs_sent++;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_plans.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [24:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_BUF) buf_bytes = value;
    else n_cores = value[7:0];
    @(posedge clk);
  endtask

  function automatic longint unsigned rand_count();
    case ($urandom_range(0, 9))
      0: return 0;
      1, 2, 3, 4: return $urandom_range(1, 4000);
      5, 6, 7: return $urandom_range(1, 1 << 20);
      default: return {$urandom, $urandom} & 64'hFF_FFFF_FFFF;
    endcase
  endfunction

  task automatic test_directed();
    longint unsigned counts[8] = '{0, 1, 31, 100, 2048, 96000, 64'hFF_FFFF_FFFF, 64'hAA_5555_AAAA};
    foreach (counts[i]) send_job(counts[i], 2'(i));
    for (int c = 0; c < 4; c++) send_job(47 * 64 + c, 2'(c));
    for (int c = 0; c < 4; c++) send_job(64'h55_AAAA_5555, 2'(c));
    drain();
  endtask

  task automatic test_config_extremes();
    logic [24:0] bufs[6] = '{25'd0, 25'd8192, 25'd8193, 25'd8208, 25'd16777216, 25'h1FFFFFF};
    logic [7:0]  cores[4] = '{8'd0, 8'd1, 8'd2, 8'd255};
    for (int b = 0; b < 6; b++) begin
      write_reg(CFG_BUF, bufs[b]);
      write_reg(CFG_CORES, 25'(cores[b % 4]));
      for (int i = 0; i < 6; i++) send_job(rand_count(), 2'($urandom_range(0, 3)));
      drain();
      write_reg(CFG_CORES, 25'(cores[(b + 2) % 4]));
      for (int i = 0; i < 6; i++) send_job(rand_count(), 2'($urandom_range(0, 3)));
      drain();
    end
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 8; ph++) begin
      no_idle = (ph % 4 == 3);
      write_reg(CFG_BUF, ph == 0 ? 25'd196608 : 25'($urandom_range(8193, 400000)));
      write_reg(CFG_CORES, 25'($urandom_range(2, 255)));
      for (int i = 0; i < 80; i++) send_job(rand_count(), 2'($urandom_range(0, 3)));
      drain();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_random_phases();
    drain();
    repeat (500) @(posedge clk);
    $display("Planned %0d copy jobs and checked %0d results, %0d of them re-planned,",
             jobs_sent, plans_checked, replans);
    $display("across buffer and core settings from zero up to the register limits.");
    if (errors == 0 && pending_plans.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
